// File: rtl/bldc_commutation_controller_assert.svh
// ----------------------------------------------------------------------------
// BLDC commutation controller assertion macros
// Shared property wrappers that are clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLDC_COMMUTATION_CONTROLLER_ASSERT_SVH
`define BLDC_COMMUTATION_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// BLDC commutation controller package
// Beat types, register block type, event and fault codes, commutation table.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);

    // Command ticks granted by each valid speed command.
    localparam logic [2:0] WATCHDOG_TICKS = 3'd4;

    // Command byte codes.
    localparam logic [7:0] CMD_STOP     = 8'd101;
    localparam logic [7:0] CMD_LIMIT    = 8'd102;
    localparam logic [7:0] CMD_FULL     = 8'd100;

    localparam logic [15:0] EDGE_COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  DUTY_MAX       = 8'hFF;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_LIMIT       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SPEED_MIN     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOSED_LOOP_EDGE_MIN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_INCREMENT      = 2'd3;

    typedef enum logic [1:0] {
        OP_EDGE    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_TICK    = 2'd2,
        OP_COMMAND = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_OVERCURRENT = 2'd1,
        FAULT_NO_COMMAND  = 2'd2
    } fault_t;

    typedef struct packed {
        op_t         operation;
        logic [2:0]  hall_code;
        logic [9:0]  current_sample;
        logic [7:0]  command_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  duty;
        logic [15:0] drive_pattern;
        logic [1:0]  drive_fault;
    } out_beat_t;

    typedef struct packed {
        logic [9:0]  current_limit;
        logic [7:0]  start_speed_min;
        logic [15:0] closed_loop_edge_min;
        logic [7:0]  ramp_increment;
    } cfg_t;

    // Six-step phase override patterns; the two invalid sensor codes drive nothing.
    function automatic logic [15:0] comm_pattern(input logic [TABLE_IDX_W-1:0] idx);
        logic [15:0] pat;
        case (idx)
            3'd0:    pat = 16'h0000;
            3'd1:    pat = 16'h0210;
            3'd2:    pat = 16'h2004;
            3'd3:    pat = 16'h0204;
            3'd4:    pat = 16'h0801;
            3'd5:    pat = 16'h0810;
            3'd6:    pat = 16'h2001;
            3'd7:    pat = 16'h0000;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bldc_commutation_controller.sv
// ----------------------------------------------------------------------------
// BLDC commutation controller
// Six-step brushless motor controller driven by sensor, current, tick and
// command events, with one result beat per event.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive as beats on the item channel (item_valid / item_ready).
// Each beat carries an operation code and the fields that operation uses.
// Every accepted beat yields exactly one result beat on the result channel
// (result_valid / result_ready) holding duty, drive pattern and fault code.
// The four control registers are written through the cfg channel, which is
// always ready; they are meant to be written only while no beat is in flight.
// A beat accepted into the input register passes through the core update into
// the result register and is presented on the result channel from there.
// Throughput is one beat per cycle while the receiver takes results, set by
// the state update between the input register and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; after that item_ready drops until
// the result is taken.
// Reset (rst_n low, asynchronous) empties both registers, clears all motor
// state to open loop with zero duty and no fault, and loads the register
// defaults: current limit 1023, ramp increment 1, the other two zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_commutation_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output      logic                            item_ready,
    input  wire bcc_pkg::in_beat_t               item,
    output      logic                            result_valid,
    input  wire logic                            result_ready,
    output bcc_pkg::out_beat_t                   result,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcc_pkg::*;

    // Input register.
    logic      s1_valid_reg, s1_valid_next;
    in_beat_t  s1_beat_reg;
    // Result register.
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_beat_reg;

    logic      item_fire;
    logic      s1_fire;
    cfg_t      cfg;
    out_beat_t core_result;

    // The input register advances whenever the result register is free or
    // being emptied in the same cycle.
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_fire;
    assign item_fire  = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_beat_reg <= item;
        end
        if (s1_fire)
        begin
            out_beat_reg <= core_result;
        end
    end

    bcc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bcc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .beat   (s1_beat_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_beat_reg;

endmodule

`default_nettype wire

// File: rtl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// BLDC commutation controller configuration registers
// Holds the four control registers written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [bcc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [bcc_pkg::CFG_DATA_W-1:0]  wr_data,
    output bcc_pkg::cfg_t                       cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_CURRENT_LIMIT:        cfg_next.current_limit        = wr_data[9:0];
                CFG_START_SPEED_MIN:      cfg_next.start_speed_min      = wr_data[7:0];
                CFG_CLOSED_LOOP_EDGE_MIN: cfg_next.closed_loop_edge_min = wr_data;
                CFG_RAMP_INCREMENT:       cfg_next.ramp_increment       = wr_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_limit        <= 10'd1023;
            cfg_reg.start_speed_min      <= 8'd0;
            cfg_reg.closed_loop_edge_min <= 16'd0;
            cfg_reg.ramp_increment       <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// BLDC commutation controller core
// Motor state registers and the combinational event update logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bldc_commutation_controller_assert.svh"

module bcc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire bcc_pkg::in_beat_t beat,
    input  wire bcc_pkg::cfg_t     cfg,
    output bcc_pkg::out_beat_t     result
);
    import bcc_pkg::*;

    logic [7:0]             duty_level_reg,     duty_level_next;
    logic [15:0]            pattern_word_reg,   pattern_word_next;
    logic [7:0]             speed_command_reg,  speed_command_next;
    logic [2:0]             watchdog_count_reg, watchdog_count_next;
    logic [TABLE_IDX_W-1:0] ramp_index_reg,     ramp_index_next;
    logic [15:0]            edge_count_reg,     edge_count_next;
    logic [9:0]             latest_current_reg, latest_current_next;
    logic                   closed_loop_reg,    closed_loop_next;
    fault_t                 fault_code_reg,     fault_code_next;

    logic [8:0] ramp_sum;
    logic [7:0] ramp_duty;

    assign ramp_sum  = {1'b0, duty_level_reg} + {1'b0, cfg.ramp_increment};
    assign ramp_duty = ramp_sum[8] ? DUTY_MAX : ramp_sum[7:0];

    always_comb
    begin
        duty_level_next     = duty_level_reg;
        pattern_word_next   = pattern_word_reg;
        speed_command_next  = speed_command_reg;
        watchdog_count_next = watchdog_count_reg;
        ramp_index_next     = ramp_index_reg;
        edge_count_next     = edge_count_reg;
        latest_current_next = latest_current_reg;
        closed_loop_next    = closed_loop_reg;
        fault_code_next     = fault_code_reg;

        case (beat.operation)
            OP_EDGE:
            begin
                if (closed_loop_reg)
                begin
                    pattern_word_next = comm_pattern(beat.hall_code);
                end
                if (edge_count_reg != EDGE_COUNT_MAX)
                begin
                    edge_count_next = edge_count_reg + 16'd1;
                end
            end
            OP_SAMPLE:
            begin
                latest_current_next = beat.current_sample;
            end
            OP_TICK:
            begin
                if (latest_current_reg > cfg.current_limit)
                begin
                    duty_level_next = '0;
                    fault_code_next = FAULT_OVERCURRENT;
                end
                else if (watchdog_count_reg != 3'd0)
                begin
                    duty_level_next = '0;
                    if (speed_command_reg > cfg.start_speed_min)
                    begin
                        if (edge_count_reg > cfg.closed_loop_edge_min)
                        begin
                            duty_level_next  = speed_command_reg;
                            closed_loop_next = 1'b1;
                        end
                        else
                        begin
                            duty_level_next   = ramp_duty;
                            closed_loop_next  = 1'b0;
                            pattern_word_next = comm_pattern(ramp_index_reg);
                            ramp_index_next   = ramp_index_reg + TABLE_IDX_W'(1);
                        end
                    end
                    watchdog_count_next = watchdog_count_reg - 3'd1;
                    fault_code_next     = FAULT_NONE;
                end
                else
                begin
                    duty_level_next = '0;
                    fault_code_next = FAULT_NO_COMMAND;
                end
                edge_count_next = '0;
            end
            OP_COMMAND:
            begin
                if ((beat.command_byte != 8'd0) && (beat.command_byte < CMD_LIMIT))
                begin
                    if (beat.command_byte == CMD_STOP)
                    begin
                        speed_command_next = '0;
                    end
                    else
                    begin
                        speed_command_next = (CMD_FULL - beat.command_byte) << 1;
                    end
                    watchdog_count_next = WATCHDOG_TICKS;
                end
            end
            default:
            begin
                duty_level_next = duty_level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_level_reg     <= '0;
            pattern_word_reg   <= '0;
            speed_command_reg  <= '0;
            watchdog_count_reg <= '0;
            ramp_index_reg     <= '0;
            edge_count_reg     <= '0;
            latest_current_reg <= '0;
            closed_loop_reg    <= 1'b0;
            fault_code_reg     <= FAULT_NONE;
        end
        else if (fire)
        begin
            duty_level_reg     <= duty_level_next;
            pattern_word_reg   <= pattern_word_next;
            speed_command_reg  <= speed_command_next;
            watchdog_count_reg <= watchdog_count_next;
            ramp_index_reg     <= ramp_index_next;
            edge_count_reg     <= edge_count_next;
            latest_current_reg <= latest_current_next;
            closed_loop_reg    <= closed_loop_next;
            fault_code_reg     <= fault_code_next;
        end
    end

    // The result carries the state as it stands after this event.
    assign result.duty          = duty_level_next;
    assign result.drive_pattern = pattern_word_next;
    assign result.drive_fault   = fault_code_next;

    `BCC_ASSERT_NEXT(a_overcurrent_stops,
        fire && beat.operation == OP_TICK && latest_current_reg > cfg.current_limit,
        duty_level_reg == 8'd0 && fault_code_reg == FAULT_OVERCURRENT,
        "overcurrent tick did not stop the motor")
    `BCC_ASSERT_NEXT(a_duty_only_on_tick,
        fire && beat.operation != OP_TICK,
        duty_level_reg == $past(duty_level_reg),
        "duty changed on an event other than a control tick")
    `BCC_ASSERT_NEXT(a_tick_clears_edges,
        fire && beat.operation == OP_TICK,
        edge_count_reg == 16'd0,
        "edge count not cleared by control tick")
    `BCC_ASSERT_IMPL(a_watchdog_bound,
        1'b1,
        watchdog_count_reg <= WATCHDOG_TICKS,
        "watchdog count above its reload value")

endmodule

`default_nettype wire

// File: bench/bcc_drive_checker.sv
// ----------------------------------------------------------------------------
// Drive result checker for the commutation controller
// Watches the item, result and register channels, keeps its own copy of the
// controller state, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module bcc_drive_checker
    import bcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  in_beat_t               item,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  out_beat_t              result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     drive_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Phase patterns, entry 0 in the low 16 bits.
    localparam logic [8*16-1:0] PHASE_PATTERNS = {
        16'h0000, 16'h2001, 16'h0810, 16'h0801,
        16'h0204, 16'h2004, 16'h0210, 16'h0000
    };

    cfg_t        regs;
    logic [7:0]  duty_now;
    logic [15:0] pattern_now;
    logic [7:0]  speed_cmd;
    logic [2:0]  wd_left;
    logic [2:0]  ramp_pos;
    logic [15:0] edges_seen;
    logic [9:0]  last_current;
    logic        loop_closed;
    fault_t      fault_now;
    out_beat_t   expected_drive[$];

    function automatic out_beat_t step_controller(input in_beat_t ev);
        logic [8:0] ramp_sum;
        logic [7:0] next_duty;
        out_beat_t  beat;
        case (ev.operation)
            OP_EDGE:
            begin
                if (loop_closed)
                    pattern_now = PHASE_PATTERNS[ev.hall_code*16 +: 16];
                if (edges_seen != EDGE_COUNT_MAX)
                    edges_seen = edges_seen + 16'd1;
            end
            OP_SAMPLE:
            begin
                last_current = ev.current_sample;
            end
            OP_TICK:
            begin
                if (last_current > regs.current_limit)
                begin
                    duty_now  = '0;
                    fault_now = FAULT_OVERCURRENT;
                end
                else if (wd_left != 3'd0)
                begin
                    next_duty = '0;
                    if (speed_cmd > regs.start_speed_min)
                    begin
                        if (edges_seen > regs.closed_loop_edge_min)
                        begin
                            next_duty   = speed_cmd;
                            loop_closed = 1'b1;
                        end
                        else
                        begin
                            ramp_sum    = {1'b0, duty_now} + {1'b0, regs.ramp_increment};
                            loop_closed = 1'b0;
                            next_duty   = (ramp_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX
                                                                       : ramp_sum[7:0];
                            pattern_now = PHASE_PATTERNS[ramp_pos*16 +: 16];
                            ramp_pos    = ramp_pos + 3'd1;
                        end
                    end
                    wd_left   = wd_left - 3'd1;
                    fault_now = FAULT_NONE;
                    duty_now  = next_duty;
                end
                else
                begin
                    duty_now  = '0;
                    fault_now = FAULT_NO_COMMAND;
                end
                edges_seen = '0;
            end
            default:
            begin
                if (ev.command_byte != 8'd0 && ev.command_byte < CMD_LIMIT)
                begin
                    if (ev.command_byte == CMD_STOP)
                        speed_cmd = '0;
                    else
                        speed_cmd = (CMD_FULL - ev.command_byte) * 8'd2;
                    wd_left = WATCHDOG_TICKS;
                end
            end
        endcase
        beat.duty          = duty_now;
        beat.drive_pattern = pattern_now;
        beat.drive_fault   = fault_now;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        out_beat_t want;
        if (!rst_n)
        begin
            regs.current_limit        = 10'd1023;
            regs.start_speed_min      = 8'd0;
            regs.closed_loop_edge_min = 16'd0;
            regs.ramp_increment       = 8'd1;
            duty_now     = '0;
            pattern_now  = '0;
            speed_cmd    = '0;
            wd_left      = '0;
            ramp_pos     = '0;
            edges_seen   = '0;
            last_current = '0;
            loop_closed  = 1'b0;
            fault_now    = FAULT_NONE;
            expected_drive.delete();
            mismatch_count = 0;
            drive_pending  = 0;
        end
        else
        begin
            // A result beat always belongs to an item taken at an earlier edge,
            // so it is retired before this edge's item is predicted.
            if (result_valid && result_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("unexpected result beat: duty %0d, drive_pattern %h, drive_fault %0d",
                           result.duty, result.drive_pattern, result.drive_fault);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (result.duty !== want.duty)
                    begin
                        $error("duty: expected %0d, actual %0d", want.duty, result.duty);
                        mismatch_count++;
                    end
                    if (result.drive_pattern !== want.drive_pattern)
                    begin
                        $error("drive_pattern: expected %h, actual %h",
                               want.drive_pattern, result.drive_pattern);
                        mismatch_count++;
                    end
                    if (result.drive_fault !== want.drive_fault)
                    begin
                        $error("drive_fault: expected %0d, actual %0d",
                               want.drive_fault, result.drive_fault);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CURRENT_LIMIT:        regs.current_limit        = cfg_data[9:0];
                    CFG_START_SPEED_MIN:      regs.start_speed_min      = cfg_data[7:0];
                    CFG_CLOSED_LOOP_EDGE_MIN: regs.closed_loop_edge_min = cfg_data;
                    CFG_RAMP_INCREMENT:       regs.ramp_increment       = cfg_data[7:0];
                    default:                  ;
                endcase
            end
            if (item_valid && item_ready)
                expected_drive.push_back(step_controller(item));
            drive_pending = expected_drive.size();
        end
    end
endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Commutation controller testbench
// Drives sensor, current, tick and command beats through the controller in
// bursts, stalls the result side on changing patterns, and reprograms the four
// control registers between phases. A checker beside the block predicts and
// compares every result beat; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bcc_pkg::*;

    // Generous bound on the whole run, far above the slowest legal pacing of
    // the directed opening plus the random phases.
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 325;

    // Result-side pacing styles.
    typedef enum int {
        PACE_OPEN,
        PACE_COIN,
        PACE_SPARSE,
        PACE_ALTERNATE
    } pace_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    in_beat_t               item;
    logic                   result_valid;
    logic                   result_ready;
    out_beat_t              result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatch_count;
    int                     drive_pending;

    // Sender pacing: beats left in the current burst.
    int                     burst_left;
    // Current limit as last programmed, so most samples can stay legal.
    logic [9:0]             limit_shadow;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bldc_commutation_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bcc_drive_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .drive_pending  (drive_pending)
    );

    function automatic in_beat_t make_event(input op_t op, input logic [2:0] hall,
                                            input logic [9:0] sample,
                                            input logic [7:0] cmd);
        in_beat_t ev;
        ev.operation      = op;
        ev.hall_code      = hall;
        ev.current_sample = sample;
        ev.command_byte   = cmd;
        return ev;
    endfunction

    // Random event weighted toward runs that keep the motor alive: frequent
    // edges, enough commands to keep the watchdog fed, and samples that mostly
    // stay within the limit. Unused fields carry random bits as well.
    function automatic in_beat_t random_event();
        in_beat_t ev;
        int       pick;
        pick              = $urandom_range(0, 99);
        ev.hall_code      = 3'($urandom_range(0, 7));
        ev.current_sample = 10'($urandom_range(0, 1023));
        ev.command_byte   = 8'($urandom_range(0, 255));
        if (pick < 40)
            ev.operation = OP_EDGE;
        else if (pick < 50)
        begin
            ev.operation = OP_SAMPLE;
            if ($urandom_range(0, 6) != 0)
                ev.current_sample = 10'($urandom_range(0, limit_shadow));
        end
        else if (pick < 72)
            ev.operation = OP_TICK;
        else
        begin
            ev.operation = OP_COMMAND;
            if ($urandom_range(0, 4) != 0)
                ev.command_byte = 8'($urandom_range(1, CMD_STOP));
        end
        return ev;
    endfunction

    // Offers one beat and returns once it is taken. Between bursts the valid
    // line drops for a random gap, sometimes of zero length.
    task automatic send_event(input in_beat_t ev);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= ev;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] reg_sel,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Every item yields a result, so the block is idle once the checker holds
    // no expectation.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        burst_left = 0;
        wait (drive_pending == 0);
    endtask

    task automatic set_controls(input logic [9:0] limit, input logic [7:0] start_min,
                                input logic [15:0] edge_min, input logic [7:0] ramp);
        write_register(CFG_CURRENT_LIMIT, {6'd0, limit});
        write_register(CFG_START_SPEED_MIN, {8'd0, start_min});
        write_register(CFG_CLOSED_LOOP_EDGE_MIN, edge_min);
        write_register(CFG_RAMP_INCREMENT, {8'd0, ramp});
        limit_shadow = limit;
    endtask

    // The result side settles into one pacing style for a random span, then draws
    // a new style at random, which may repeat. Open spans give stretches with no stalls at all.
    initial
    begin : result_pacing
        pace_t style;
        int    span;
        bit    parity;
        result_ready = 1'b0;
        parity       = 1'b0;
        forever
        begin
            style = pace_t'($urandom_range(0, 3));
            span  = $urandom_range(8, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (style)
                    PACE_OPEN:   result_ready <= 1'b1;
                    PACE_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
                    PACE_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        parity = ~parity;
                        result_ready <= parity;
                    end
                endcase
            end
        end
    end

    // Hard stop in case the block hangs a handshake.
    initial
    begin : run_limit
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_CURRENT_LIMIT;
        cfg_data     = '0;
        burst_left   = 0;
        limit_shadow = 10'd1023;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening with the reset register values. A tick before any
        // command must report the missing command.
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        // Edges in open loop only count; the pattern stays put.
        send_event(make_event(OP_EDGE, 3'd0, 10'd0, 8'd0));
        send_event(make_event(OP_EDGE, 3'd7, 10'd0, 8'd0));
        // Zero and anything above the stop code are ignored and do not feed
        // the watchdog, so the next tick still reports no command.
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, 8'd0));
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, CMD_LIMIT));
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, 8'd255));
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        // Full-scale command means zero speed, which is not above the minimum.
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, CMD_FULL));
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        // Mid speed with no edges since the last tick: two open-loop ramp steps.
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, 8'd50));
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        // One edge is enough to switch to closed loop with the default minimum.
        send_event(make_event(OP_EDGE, 3'd5, 10'd0, 8'd0));
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        // Closed loop: each edge loads the pattern for its sensor code.
        send_event(make_event(OP_EDGE, 3'd1, 10'd0, 8'd0));
        send_event(make_event(OP_EDGE, 3'd4, 10'd0, 8'd0));
        send_event(make_event(OP_EDGE, 3'd6, 10'd0, 8'd0));
        // A sample at the default limit is not overcurrent.
        send_event(make_event(OP_SAMPLE, 3'd0, 10'd1023, 8'd0));
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, 8'd1));
        send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        // Stop zeroes the speed but still renews the watchdog; five ticks run it
        // down and then report the missing command.
        send_event(make_event(OP_COMMAND, 3'd0, 10'd0, CMD_STOP));
        repeat (5) send_event(make_event(OP_TICK, 3'd0, 10'd0, 8'd0));
        drain();

        // Random phases, each under its own register setting. The first two
        // pin every register to an extreme; the last one stops the ramp.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_controls(10'd0, 8'd255, 16'hFFFF, 8'd255);
                1: set_controls(10'd1023, 8'd0, 16'd0, 8'd255);
                PHASE_COUNT - 1:
                    set_controls(10'($urandom_range(300, 1023)), 8'($urandom_range(0, 120)),
                                 16'($urandom_range(0, 6)), 8'd0);
                default:
                    set_controls(10'($urandom_range(300, 1023)), 8'($urandom_range(0, 120)),
                                 16'($urandom_range(0, 6)), 8'($urandom_range(1, 64)));
            endcase
            repeat (PHASE_ITEMS) send_event(random_event());
            drain();
        end

        // Let the result side settle before the verdict.
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && drive_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
